[design/csn_pkg.sv]
// Shared types and constants for the calibrated sensor normalizer.
package csn_pkg;

    // Field widths fixed by the item format
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned VAL_W   = 12;
    localparam int unsigned PROD_W  = 2 * VAL_W;
    localparam int unsigned APB_DW  = 32;
    localparam int unsigned APB_AW  = 3;

    // Command codes on the input channel
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CAL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NORM  = 2'd2;

    // Register index of full_scale (taken from paddr[2])
    localparam logic REG_FULL_SCALE = 1'b0;

    // Reset values
    localparam logic [VAL_W-1:0] MAX_RESET   = 12'd0;
    localparam logic [VAL_W-1:0] MIN_RESET   = 12'd1500;
    localparam logic [VAL_W-1:0] SCALE_RESET = 12'd1000;

    // Classified operation handed from front to back
    typedef enum logic [2:0] {
        OP_CLEAR = 3'd0,
        OP_CAL   = 3'd1,
        OP_NORM  = 3'd2,
        OP_NOP   = 3'd3,
        OP_RANGE = 3'd4
    } t_op;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  sample;
    } t_in;

    typedef struct packed {
        logic [CHAN_W-1:0] out_channel;
        logic [VAL_W-1:0]  level;
        logic              flat_range;
        logic [VAL_W-1:0]  cal_max;
        logic [VAL_W-1:0]  cal_min;
    } t_out;

    typedef struct packed {
        t_op               op;
        logic [CHAN_W-1:0] channel;
        logic [VAL_W-1:0]  sample;
    } t_job;

endpackage

[design/csn_front.sv]
// Front end: accepts input transactions, classifies them and pushes jobs.
module csn_front #(
    parameter int unsigned CHAN_COUNT  = 14,
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic          i_in_valid,
    input  csn_pkg::t_in  i_in_data,
    input  logic          i_full,
    output logic          o_in_stall,
    output logic          o_push,
    output csn_pkg::t_job o_job
);

    localparam logic [csn_pkg::VAL_W-1:0] SAMPLE_MASK =
        csn_pkg::VAL_W'((32'd1 << SAMPLE_BITS) - 32'd1);

    logic w_in_range;

    // Stall while the job queue has no room
    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign w_in_range = ({28'd0, i_in_data.channel} < 32'(CHAN_COUNT));

    // Decode the command into an operation for the back end
    always_comb begin
        o_job.channel = i_in_data.channel;
        o_job.sample  = i_in_data.sample & SAMPLE_MASK;
        if (!w_in_range) begin
            o_job.op = csn_pkg::OP_RANGE;
        end else begin
            unique case (i_in_data.cmd)
                csn_pkg::CMD_CLEAR: o_job.op = csn_pkg::OP_CLEAR;
                csn_pkg::CMD_CAL:   o_job.op = csn_pkg::OP_CAL;
                csn_pkg::CMD_NORM:  o_job.op = csn_pkg::OP_NORM;
                default:            o_job.op = csn_pkg::OP_NOP;
            endcase
        end
    end

endmodule

[design/csn_queue.sv]
// Two-entry job queue between the front and back ends.
module csn_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  csn_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output csn_pkg::t_job o_job
);

    csn_pkg::t_job r_mem [2];
    logic          r_wr_ptr;
    logic          r_rd_ptr;
    logic [1:0]    r_count;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= !r_wr_ptr;
            if (w_pop)  r_rd_ptr <= !r_rd_ptr;
            if (w_push && !w_pop)      r_count <= r_count + 2'd1;
            else if (w_pop && !w_push) r_count <= r_count - 2'd1;
        end
    end

    // Store the pushed job
    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_job;
    end

endmodule

[design/csn_back.sv]
// Back end: calibration tables, normalize datapath with radix-4 divider, output register.
module csn_back #(
    parameter int unsigned CHAN_COUNT = 14
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [csn_pkg::VAL_W-1:0]  i_full_scale,
    input  logic                       i_job_valid,
    input  csn_pkg::t_job              i_job,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output csn_pkg::t_out              o_out_data
);

    localparam int unsigned STORE_DEPTH = (CHAN_COUNT > 16) ? 16 : CHAN_COUNT;
    localparam int unsigned IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int unsigned VW          = csn_pkg::VAL_W;
    localparam int unsigned PW          = csn_pkg::PROD_W;
    localparam int unsigned DIV_STEPS   = PW / 2;
    localparam int unsigned CNT_W       = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic [VW-1:0]   r_track_max [STORE_DEPTH];
    logic [VW-1:0]   r_track_min [STORE_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic            r_out_valid;
    csn_pkg::t_out   r_out;

    logic [csn_pkg::CHAN_W-1:0] r_ch;
    logic [VW-1:0]   r_hi;
    logic [VW-1:0]   r_lo;
    logic [VW-1:0]   r_diff;
    logic [VW-1:0]   r_den;
    logic [VW-1:0]   r_scale;
    logic [PW-1:0]   r_num;
    logic [VW-1:0]   r_rem;
    logic [PW-1:0]   r_quo;

    logic            w_out_free;
    logic            w_pop;
    logic            w_load;
    logic            w_start_div;
    logic            w_wr_track;
    logic [IDX_W-1:0] w_idx;
    logic [VW-1:0]   w_hi;
    logic [VW-1:0]   w_lo;
    logic [VW-1:0]   w_s;
    logic [VW-1:0]   w_new_hi;
    logic [VW-1:0]   w_new_lo;
    logic            w_up;
    logic            w_pos;
    logic [VW-1:0]   w_diff;
    logic [VW-1:0]   w_den;
    csn_pkg::t_out   w_out;
    logic [VW:0]     w_t1;
    logic [VW:0]     w_t2;
    logic            w_b1;
    logic            w_b2;
    logic [VW-1:0]   w_rem1;
    logic [VW-1:0]   w_rem2;
    logic [VW-1:0]   w_level;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_pop       = (r_state == S_IDLE) && i_job_valid && w_out_free;
    assign o_pop       = w_pop;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Read the channel's tracked range
    assign w_idx = i_job.channel[IDX_W-1:0];
    assign w_hi  = r_track_max[w_idx];
    assign w_lo  = r_track_min[w_idx];
    assign w_s   = i_job.sample;

    // Calibrate: widen the range independently on each side
    assign w_new_hi = (w_s > w_hi) ? w_s : w_hi;
    assign w_new_lo = (w_s < w_lo) ? w_s : w_lo;

    // Normalize setup: fold the sign so the divider sees magnitudes only
    assign w_up   = (w_hi > w_lo);
    assign w_pos  = w_up ? (w_s > w_lo) : (w_s < w_lo);
    assign w_diff = w_up ? (w_s - w_lo) : (w_lo - w_s);
    assign w_den  = w_up ? (w_hi - w_lo) : (w_lo - w_hi);

    // Build the immediate result for the job at the head of the queue
    always_comb begin
        w_out             = '0;
        w_out.out_channel = i_job.channel;
        w_start_div       = 1'b0;
        w_wr_track        = 1'b0;
        case (i_job.op)
            csn_pkg::OP_CLEAR: begin
                w_wr_track    = 1'b1;
                w_out.cal_max = csn_pkg::MAX_RESET;
                w_out.cal_min = csn_pkg::MIN_RESET;
            end
            csn_pkg::OP_CAL: begin
                w_wr_track    = 1'b1;
                w_out.cal_max = w_new_hi;
                w_out.cal_min = w_new_lo;
            end
            csn_pkg::OP_NORM: begin
                w_out.cal_max = w_hi;
                w_out.cal_min = w_lo;
                if (w_hi == w_lo) begin
                    w_out.flat_range = 1'b1;
                    w_out.level      = (w_s > w_lo) ? i_full_scale : '0;
                end else if (w_pos) begin
                    w_start_div = 1'b1;
                end
            end
            csn_pkg::OP_NOP: begin
                w_out.cal_max = w_hi;
                w_out.cal_min = w_lo;
            end
            default: begin
                w_out.cal_max = '0;
                w_out.cal_min = '0;
            end
        endcase
    end

    // Two restoring division steps per cycle
    assign w_t1   = {r_rem, r_num[PW-1]};
    assign w_b1   = (w_t1 >= {1'b0, r_den});
    assign w_rem1 = w_b1 ? VW'(w_t1 - {1'b0, r_den}) : w_t1[VW-1:0];
    assign w_t2   = {w_rem1, r_num[PW-2]};
    assign w_b2   = (w_t2 >= {1'b0, r_den});
    assign w_rem2 = w_b2 ? VW'(w_t2 - {1'b0, r_den}) : w_t2[VW-1:0];

    // Clamp the quotient to full scale
    assign w_level = (r_quo > {{(PW-VW){1'b0}}, r_scale}) ? r_scale : r_quo[VW-1:0];

    assign w_load = (w_pop && !w_start_div) || ((r_state == S_DONE) && w_out_free);

    // Sequence a normalize through multiply and divide
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_pop && w_start_div) n_state = S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_cnt == CNT_W'(DIV_STEPS - 1)) n_state = S_DONE;
            S_DONE: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control state and calibration tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
                r_track_max[i] <= csn_pkg::MAX_RESET;
                r_track_min[i] <= csn_pkg::MIN_RESET;
            end
        end else begin
            r_state <= n_state;
            if (r_state == S_MUL)      r_cnt <= '0;
            else if (r_state == S_DIV) r_cnt <= r_cnt + CNT_W'(1);
            if (w_load)                r_out_valid <= 1'b1;
            else if (!i_out_stall)     r_out_valid <= 1'b0;
            if (w_pop && w_wr_track) begin
                r_track_max[w_idx] <= w_out.cal_max;
                r_track_min[w_idx] <= w_out.cal_min;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_ch    <= i_job.channel;
            r_hi    <= w_hi;
            r_lo    <= w_lo;
            r_diff  <= w_diff;
            r_den   <= w_den;
            r_scale <= i_full_scale;
        end
        if (r_state == S_MUL) begin
            r_num <= PW'(r_diff) * PW'(r_scale);
            r_rem <= '0;
        end else if (r_state == S_DIV) begin
            r_num <= {r_num[PW-3:0], 2'b00};
            r_rem <= w_rem2;
            r_quo <= {r_quo[PW-3:0], w_b1, w_b2};
        end
        if (w_pop && !w_start_div) begin
            r_out <= w_out;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_out.out_channel <= r_ch;
            r_out.level       <= w_level;
            r_out.flat_range  <= 1'b0;
            r_out.cal_max     <= r_hi;
            r_out.cal_min     <= r_lo;
        end
    end

endmodule

[design/calibrated_sensor_normalizer.sv]
// Top level: APB register, front end, job queue and back end of the normalizer.
// Path: clear, calibrate and trivial normalize pass through the queue entry and the output register;
// a normalize that divides passes queue, setup, multiply, 12 radix-4 divider steps and clamp.
// Flow: up to one item per cycle for non-dividing jobs while the output is not stalled; the
// iterative divider in the back end takes no new job until a dividing normalize is done.
// Reset (synchronous, active low): maxima to 0, minima to 1500, full_scale to 1000, queue empty.
module calibrated_sensor_normalizer #(
    parameter int unsigned MAIN_CHANNELS = 12,
    parameter int unsigned SIDE_CHANNELS = 2,
    parameter int unsigned SAMPLE_BITS   = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  csn_pkg::t_in                  i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output csn_pkg::t_out                 o_out_data,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [csn_pkg::APB_AW-1:0]    paddr,
    input  logic [csn_pkg::APB_DW-1:0]    pwdata,
    output logic [csn_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int unsigned CHAN_COUNT = MAIN_CHANNELS + SIDE_CHANNELS;

    logic [csn_pkg::VAL_W-1:0] r_full_scale;
    logic                      w_sel_scale;
    logic                      w_full;
    logic                      w_push;
    logic                      w_pop;
    logic                      w_job_valid;
    csn_pkg::t_job             w_job_in;
    csn_pkg::t_job             w_job_out;

    // Register decode: word index from paddr[2]
    assign pready      = 1'b1;
    assign w_sel_scale = (paddr[2] == csn_pkg::REG_FULL_SCALE);
    assign prdata      = w_sel_scale ?
        {{(csn_pkg::APB_DW-csn_pkg::VAL_W){1'b0}}, r_full_scale} : '0;

    // Write full_scale on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_scale <= csn_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_scale) begin
            r_full_scale <= pwdata[csn_pkg::VAL_W-1:0];
        end
    end

    csn_front #(
        .CHAN_COUNT  (CHAN_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (w_full),
        .o_in_stall (o_in_stall),
        .o_push     (w_push),
        .o_job      (w_job_in)
    );

    csn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_job_valid),
        .o_job   (w_job_out)
    );

    csn_back #(
        .CHAN_COUNT (CHAN_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_scale (r_full_scale),
        .i_job_valid  (w_job_valid),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

[bench/tb_calibrated_sensor_normalizer.sv]
// Self-checking testbench for the calibrated sensor normalizer: directed table, then random traffic.
`timescale 1ns / 100ps

module tb_calibrated_sensor_normalizer;

    localparam int unsigned CHANNELS     = 14;
    localparam int unsigned RAND_ITEMS   = 750;
    localparam int unsigned PHASES       = 6;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned DIR_ROWS     = 25;

    // Command code the block must treat as a no-op
    localparam logic [csn_pkg::CMD_W-1:0]  CMD_UNUSED      = 2'd3;
    localparam logic [csn_pkg::APB_AW-1:0] FULL_SCALE_ADDR = {csn_pkg::REG_FULL_SCALE, 2'b00};

    typedef struct packed {
        csn_pkg::t_in  item;
        logic          typed;
        csn_pkg::t_out result;
    } t_dir_row;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_in_valid;
    logic                          o_in_stall;
    csn_pkg::t_in                  i_in_data;
    logic                          o_out_valid;
    logic                          i_out_stall;
    csn_pkg::t_out                 o_out_data;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [csn_pkg::APB_AW-1:0]    paddr;
    logic [csn_pkg::APB_DW-1:0]    pwdata;
    logic [csn_pkg::APB_DW-1:0]    prdata;
    logic                          pready;

    // Shadow calibration state and scale
    logic [csn_pkg::VAL_W-1:0] trk_max [CHANNELS];
    logic [csn_pkg::VAL_W-1:0] trk_min [CHANNELS];
    logic [csn_pkg::VAL_W-1:0] scale_now;

    csn_pkg::t_out due_results [$];
    int unsigned   mismatches;
    int unsigned   idle_cycles;
    int unsigned   burst_left;
    bit            valid_up;

    // Directed rows: typed result only where it is plain from the rule
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{'{csn_pkg::CMD_CLEAR, 4'd0, 12'hFFF}, 1'b1,
          '{4'd0, 12'd0, 1'b0, 12'd0, 12'd1500}},
        '{'{CMD_UNUSED, 4'd13, 12'h000}, 1'b1,
          '{4'd13, 12'd0, 1'b0, 12'd0, 12'd1500}},
        '{'{csn_pkg::CMD_CAL, 4'd15, 12'hFFF}, 1'b1,
          '{4'd15, 12'd0, 1'b0, 12'd0, 12'd0}},
        '{'{csn_pkg::CMD_NORM, 4'd14, 12'h000}, 1'b1,
          '{4'd14, 12'd0, 1'b0, 12'd0, 12'd0}},
        '{'{csn_pkg::CMD_NORM, 4'd1, 12'hFFF}, 1'b0, '0},
        '{'{csn_pkg::CMD_NORM, 4'd2, 12'h000}, 1'b0, '0},
        '{'{csn_pkg::CMD_CAL, 4'd3, 12'hFFF}, 1'b1,
          '{4'd3, 12'd0, 1'b0, 12'd4095, 12'd1500}},
        '{'{csn_pkg::CMD_CAL, 4'd3, 12'h000}, 1'b1,
          '{4'd3, 12'd0, 1'b0, 12'd4095, 12'd0}},
        '{'{csn_pkg::CMD_NORM, 4'd3, 12'hFFF}, 1'b1,
          '{4'd3, 12'd1000, 1'b0, 12'd4095, 12'd0}},
        '{'{csn_pkg::CMD_NORM, 4'd3, 12'h000}, 1'b1,
          '{4'd3, 12'd0, 1'b0, 12'd4095, 12'd0}},
        '{'{csn_pkg::CMD_NORM, 4'd3, 12'h800}, 1'b0, '0},
        '{'{csn_pkg::CMD_CAL, 4'd4, 12'd1500}, 1'b1,
          '{4'd4, 12'd0, 1'b0, 12'd1500, 12'd1500}},
        '{'{csn_pkg::CMD_NORM, 4'd4, 12'd1501}, 1'b1,
          '{4'd4, 12'd1000, 1'b1, 12'd1500, 12'd1500}},
        '{'{csn_pkg::CMD_NORM, 4'd4, 12'd1500}, 1'b1,
          '{4'd4, 12'd0, 1'b1, 12'd1500, 12'd1500}},
        '{'{csn_pkg::CMD_NORM, 4'd4, 12'd0}, 1'b0, '0},
        '{'{csn_pkg::CMD_CAL, 4'd12, 12'd100}, 1'b0, '0},
        '{'{csn_pkg::CMD_CAL, 4'd12, 12'd900}, 1'b0, '0},
        '{'{csn_pkg::CMD_NORM, 4'd12, 12'd500}, 1'b0, '0},
        '{'{csn_pkg::CMD_CAL, 4'd13, 12'd2000}, 1'b0, '0},
        '{'{csn_pkg::CMD_NORM, 4'd13, 12'd1000}, 1'b0, '0},
        '{'{csn_pkg::CMD_NORM, 4'd13, 12'd3000}, 1'b0, '0},
        '{'{csn_pkg::CMD_CLEAR, 4'd3, 12'h555}, 1'b1,
          '{4'd3, 12'd0, 1'b0, 12'd0, 12'd1500}},
        '{'{csn_pkg::CMD_CAL, 4'd11, 12'hAAA}, 1'b0, '0},
        '{'{csn_pkg::CMD_NORM, 4'd11, 12'h555}, 1'b0, '0},
        '{'{CMD_UNUSED, 4'd15, 12'hFFF}, 1'b1,
          '{4'd15, 12'd0, 1'b0, 12'd0, 12'd0}}
    };

    calibrated_sensor_normalizer DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the shadow calibration by one transaction and return its result
    function automatic csn_pkg::t_out normalize_step(input csn_pkg::t_in it);
        csn_pkg::t_out r;
        longint        num;
        longint        den;
        longint        q;
        r = '0;
        r.out_channel = it.channel;
        if (it.channel >= CHANNELS) return r;
        case (it.cmd)
            csn_pkg::CMD_CLEAR: begin
                trk_max[it.channel] = csn_pkg::MAX_RESET;
                trk_min[it.channel] = csn_pkg::MIN_RESET;
            end
            csn_pkg::CMD_CAL: begin
                if (it.sample > trk_max[it.channel]) trk_max[it.channel] = it.sample;
                if (it.sample < trk_min[it.channel]) trk_min[it.channel] = it.sample;
            end
            csn_pkg::CMD_NORM: begin
                if (trk_max[it.channel] == trk_min[it.channel]) begin
                    r.flat_range = 1'b1;
                    r.level = (it.sample > trk_min[it.channel]) ? scale_now : '0;
                end else begin
                    // Signed quotient, truncated toward zero, then clamped
                    num = (longint'(it.sample) - longint'(trk_min[it.channel]))
                          * longint'(scale_now);
                    den = longint'(trk_max[it.channel]) - longint'(trk_min[it.channel]);
                    q = num / den;
                    if (q < 0) q = 0;
                    if (q > longint'(scale_now)) q = longint'(scale_now);
                    r.level = q[csn_pkg::VAL_W-1:0];
                end
            end
            default: ;
        endcase
        r.cal_max = trk_max[it.channel];
        r.cal_min = trk_min[it.channel];
        return r;
    endfunction

    // Draw a random transaction, biased toward the channel's calibrated span
    function automatic csn_pkg::t_in pick_item();
        csn_pkg::t_in it;
        int unsigned  roll;
        int           v;
        roll = $urandom_range(0, 99);
        if (roll < 8)       it.cmd = csn_pkg::CMD_CLEAR;
        else if (roll < 45) it.cmd = csn_pkg::CMD_CAL;
        else if (roll < 96) it.cmd = csn_pkg::CMD_NORM;
        else                it.cmd = CMD_UNUSED;
        if ($urandom_range(0, 19) == 0)
            it.channel = csn_pkg::CHAN_W'($urandom_range(14, 15));
        else
            it.channel = csn_pkg::CHAN_W'($urandom_range(0, 13));
        it.sample = csn_pkg::VAL_W'($urandom);
        roll = $urandom_range(0, 3);
        if (roll == 1) begin
            case ($urandom_range(0, 2))
                0:       it.sample = '0;
                1:       it.sample = '1;
                default: it.sample = csn_pkg::MIN_RESET;
            endcase
        end else if (roll >= 2 && it.channel < CHANNELS) begin
            if (roll == 2 || trk_max[it.channel] <= trk_min[it.channel]) begin
                v = $urandom_range(0, 1) ? int'(trk_max[it.channel])
                                         : int'(trk_min[it.channel]);
                v = v + int'($urandom_range(0, 6)) - 3;
                if (v < 0) v = 0;
                if (v > 4095) v = 4095;
                it.sample = csn_pkg::VAL_W'(v);
            end else begin
                it.sample = csn_pkg::VAL_W'($urandom_range(trk_min[it.channel],
                                                           trk_max[it.channel]));
            end
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatches++;
        $display("%0t: %s mismatch, got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic check_result(input csn_pkg::t_out got, input csn_pkg::t_out want);
        if (got.out_channel !== want.out_channel)
            report_mismatch("out_channel", got.out_channel, want.out_channel);
        if (got.level !== want.level)
            report_mismatch("level", got.level, want.level);
        if (got.flat_range !== want.flat_range)
            report_mismatch("flat_range", got.flat_range, want.flat_range);
        if (got.cal_max !== want.cal_max)
            report_mismatch("cal_max", got.cal_max, want.cal_max);
        if (got.cal_min !== want.cal_min)
            report_mismatch("cal_min", got.cal_min, want.cal_min);
    endtask

    // Present one transaction, hold it until taken, queue its result, and pause between random bursts
    task automatic send_item(input csn_pkg::t_in it, input logic typed,
                             input csn_pkg::t_out typed_res);
        csn_pkg::t_out want;
        int unsigned   gap;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        valid_up = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        want = normalize_step(it);
        if (typed) want = typed_res;
        due_results.push_back(want);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold the sender until every pending result has come back
    task automatic wait_drained();
        if (valid_up) begin
            i_in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write full_scale, then read it back
    task automatic set_full_scale(input logic [csn_pkg::VAL_W-1:0] value);
        logic [csn_pkg::APB_DW-1:0] rd;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FULL_SCALE_ADDR;
        pwdata  <= csn_pkg::APB_DW'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        scale_now = value;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (rd[csn_pkg::VAL_W-1:0] !== value)
            report_mismatch("full_scale readback", rd[csn_pkg::VAL_W-1:0], value);
    endtask

    // Check each accepted result against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_results.size() == 0)
                report_mismatch("unexpected result on channel", o_out_data.out_channel, 0);
            else
                check_result(o_out_data, due_results.pop_front());
        end
    end

    // Drop the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver stall: switch among quiet, light, heavy and periodic patterns
    initial begin
        int unsigned span;
        int unsigned mode;
        int unsigned ph;
        i_out_stall <= 1'b0;
        span = 0;
        mode = 0;
        ph = 0;
        forever begin
            @(posedge i_clk);
            if (span == 0) begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(16, 96);
            end
            span--;
            ph++;
            case (mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 1) == 0);
                default: i_out_stall <= ((ph % 7) < 3);
            endcase
        end
    end

    initial begin
        logic [csn_pkg::VAL_W-1:0] scale_plan [PHASES];
        int unsigned               per_phase;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        mismatches  = 0;
        idle_cycles = 0;
        burst_left  = 0;
        valid_up    = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            trk_max[i] = csn_pkg::MAX_RESET;
            trk_min[i] = csn_pkg::MIN_RESET;
        end
        scale_now = csn_pkg::SCALE_RESET;
        scale_plan[0] = 12'd4095;
        scale_plan[1] = 12'd1;
        scale_plan[2] = 12'd0;
        scale_plan[3] = csn_pkg::VAL_W'($urandom_range(2, 4094));
        scale_plan[4] = csn_pkg::SCALE_RESET;
        scale_plan[5] = csn_pkg::VAL_W'($urandom_range(2, 4094));
        per_phase = RAND_ITEMS / PHASES;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset scale
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].result);

        // Random phases, each at its own scale, written while idle
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            set_full_scale(scale_plan[p]);
            for (int n = 0; n < per_phase; n++) begin
                if (p == 0 && n == per_phase / 2) wait_drained();
                send_item(pick_item(), 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[calibrated_sensor_normalizer.f]
design/csn_pkg.sv
design/csn_front.sv
design/csn_queue.sv
design/csn_back.sv
design/calibrated_sensor_normalizer.sv
bench/tb_calibrated_sensor_normalizer.sv
